### rtl/lphash_pkg.sv
// shared types and constants for the linear probing hash table
// no dependencies; used by the store, sequencer, top level and checker
package lphash_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BYTES   = 32;

  localparam int CNT_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] OP_GET   = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_DEL   = 3'd2;
  localparam logic [2:0] OP_SUM   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_DEL_LOW  = 2'd3;

  localparam logic [1:0] TAG_EMPTY   = 2'd0;
  localparam logic [1:0] TAG_LIVE    = 2'd1;
  localparam logic [1:0] TAG_DELETED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 2'd2;

  localparam logic [CNT_W-1:0] RST_BUCKETS = 11'd1024;
  localparam logic [CNT_W-1:0] RST_UPPER   = 11'd921;
  localparam logic [CNT_W-1:0] RST_LOWER   = 11'd0;

  typedef struct packed {
    logic rd;
    logic tag_we;
    logic key_we;
    logic val_we;
  } store_ctl_t;

endpackage

### rtl/lphash_if.sv
// channel interfaces: request, response and register write
// no dependencies
interface lphash_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic [63:0]         key_w0;
  logic [63:0]         key_w1;
  logic [63:0]         key_w2;
  logic [63:0]         key_w3;
  logic signed [31:0]  value_w0;
  logic signed [31:0]  value_w1;
  logic signed [31:0]  value_w2;
  modport source (output valid, opcode, key_w0, key_w1, key_w2, key_w3,
                  value_w0, value_w1, value_w2, input ready);
  modport sink (input valid, opcode, key_w0, key_w1, key_w2, key_w3,
                value_w0, value_w1, value_w2, output ready);
endinterface

interface lphash_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic signed [31:0]  found_w0;
  logic signed [31:0]  found_w1;
  logic signed [31:0]  found_w2;
  logic [10:0]         entries_now;
  logic signed [63:0]  sum_prod_w1;
  logic signed [63:0]  sum_prod_w2;
  logic signed [63:0]  sum_w1;
  logic signed [63:0]  sum_w2;
  modport source (output valid, status, found_w0, found_w1, found_w2, entries_now,
                  sum_prod_w1, sum_prod_w2, sum_w1, sum_w2, input ready);
  modport sink (input valid, status, found_w0, found_w1, found_w2, entries_now,
                sum_prod_w1, sum_prod_w2, sum_w1, sum_w2, output ready);
endinterface

interface lphash_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [10:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### rtl/lphash_mod.sv
// iterative remainder unit, one quotient bit per cycle
// depends on nothing beyond its parameters
module lphash_mod #(
  parameter int NW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] rem
);
  logic          busy;
  logic [4:0]    cnt;
  logic [31:0]   dvd;
  logic [NW-1:0] r;
  logic [NW:0]   t;
  logic [NW:0]   t_sub;

  always_comb begin
    t = {r, dvd[31]};
    t_sub = (t >= {1'b0, divisor}) ? t - {1'b0, divisor} : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        r    <= '0;
      end else if (busy) begin
        r   <= t_sub[NW-1:0];
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r;
endmodule

### rtl/lphash_store.sv
// bucket storage: tag, key and value memories, one shared address, registered reads
// depends on lphash_pkg
module lphash_store #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KW = 256,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  lphash_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]          addr,
  input  logic [1:0]             tag_wd,
  input  logic [KW-1:0]          key_wd,
  input  logic [95:0]            val_wd,
  output logic [1:0]             rd_tag,
  output logic [KW-1:0]          rd_key,
  output logic [95:0]            rd_val
);
  import lphash_pkg::*;

  logic [1:0]    tag_mem [TABLE_DEPTH];
  logic [KW-1:0] key_mem [TABLE_DEPTH];
  logic [95:0]   val_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.tag_we) tag_mem[addr] <= tag_wd;
    if (ctl.rd) rd_tag <= tag_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.key_we) key_mem[addr] <= key_wd;
    if (ctl.rd) rd_key <= key_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.val_we) val_mem[addr] <= val_wd;
    if (ctl.rd) rd_val <= val_mem[addr];
  end
endmodule

### rtl/lphash_ctrl.sv
// operation sequencer: probing, insert, delete, summarize sweep, clear sweep,
// config registers and response register; depends on lphash_pkg and lphash_if
module lphash_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES = 32,
  parameter int AW = $clog2(TABLE_DEPTH),
  parameter int NW = AW + 1,
  parameter int KW = KEY_BYTES * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  lphash_in_if.sink              req,
  lphash_out_if.source           rsp,
  lphash_cfg_if.sink             cfg,
  output logic                   div_start,
  output logic [NW-1:0]          div_n,
  input  logic                   div_done,
  input  logic [NW-1:0]          div_rem,
  output lphash_pkg::store_ctl_t ctl,
  output logic [AW-1:0]          addr,
  output logic [1:0]             tag_wd,
  output logic [KW-1:0]          key_wd,
  output logic [95:0]            val_wd,
  input  logic [1:0]             rd_tag,
  input  logic [KW-1:0]          rd_key,
  input  logic [95:0]            rd_val
);
  import lphash_pkg::*;

  localparam int CW = (NW > CNT_W) ? NW : CNT_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_FRD, S_FCHK, S_MOVE1, S_MOVE2, S_HIT,
    S_SRD, S_SCHK, S_SUMRD, S_SUMCHK, S_SUMM2, S_SUMM3, S_DONE
  } state_t;

  state_t              state;
  logic                clr_op;
  logic [2:0]          op;
  logic [KW-1:0]       key;
  logic [95:0]         val;
  logic [AW-1:0]       start;
  logic [AW-1:0]       tomb;
  logic                have_tomb;
  logic [AW-1:0]       hit;
  logic [NW-1:0]       tries;
  logic [CW-1:0]       count;
  logic [CNT_W-1:0]    bucket_cfg;
  logic [CNT_W-1:0]    upper_cfg;
  logic [CNT_W-1:0]    lower_cfg;
  logic [1:0]          res_status;
  logic [95:0]         res_found;
  logic signed [63:0]  s_tot;
  logic signed [63:0]  s_ctot;
  logic signed [63:0]  s_u;
  logic signed [63:0]  s_cu;
  logic signed [63:0]  prod;
  logic                out_valid;

  logic [NW-1:0]       n;
  logic [NW-1:0]       addr_inc;
  logic [AW-1:0]       nb;
  logic                wrap_end;
  logic [CW-1:0]       count_dec;
  logic signed [31:0]  va;
  logic signed [31:0]  vb;
  logic signed [31:0]  vc;
  logic signed [31:0]  mul_b;
  logic [255:0]        key_in;

  always_comb begin
    if (bucket_cfg == '0) n = NW'(1);
    else if (CW'(bucket_cfg) > CW'(TABLE_DEPTH)) n = NW'(TABLE_DEPTH);
    else n = NW'(bucket_cfg);
    addr_inc = {1'b0, addr} + NW'(1);
    wrap_end = (addr_inc == n);
    nb = wrap_end ? '0 : addr_inc[AW-1:0];
    count_dec = (count != '0) ? count - CW'(1) : count;
    va = rd_val[31:0];
    vb = rd_val[63:32];
    vc = rd_val[95:64];
    mul_b = (state == S_SUMCHK) ? vb : vc;
    key_in = {req.key_w3, req.key_w2, req.key_w1, req.key_w0};
  end

  assign div_n = n;
  assign div_start = (state == S_IDLE) && req.valid &&
                     (req.opcode inside {OP_GET, OP_SET, OP_DEL});
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    ctl = '0;
    tag_wd = TAG_EMPTY;
    key_wd = key;
    val_wd = val;
    case (state)
      S_CLR: ctl.tag_we = 1'b1;
      S_FRD, S_SRD, S_SUMRD: ctl.rd = 1'b1;
      S_MOVE1: begin
        ctl.tag_we = 1'b1;
        ctl.key_we = 1'b1;
        ctl.val_we = 1'b1;
        tag_wd = TAG_LIVE;
        key_wd = rd_key;
        val_wd = rd_val;
      end
      S_MOVE2: begin
        ctl.tag_we = 1'b1;
        tag_wd = TAG_DELETED;
      end
      S_HIT: begin
        if (op == OP_SET) ctl.val_we = 1'b1;
        if (op == OP_DEL) begin
          ctl.tag_we = 1'b1;
          tag_wd = TAG_DELETED;
        end
      end
      S_SCHK: begin
        if (rd_tag != TAG_LIVE) begin
          ctl.tag_we = 1'b1;
          ctl.key_we = 1'b1;
          ctl.val_we = 1'b1;
          tag_wd = TAG_LIVE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      addr       <= '0;
      clr_op     <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
      bucket_cfg <= RST_BUCKETS;
      upper_cfg  <= RST_UPPER;
      lower_cfg  <= RST_LOWER;
    end else begin
      if (cfg.valid) begin
        case (cfg.addr)
          REG_BUCKETS: bucket_cfg <= cfg.data;
          REG_UPPER:   upper_cfg <= cfg.data;
          REG_LOWER:   lower_cfg <= cfg.data;
          default: ;
        endcase
      end
      if (out_valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_CLR: begin
          if (addr == AW'(TABLE_DEPTH - 1)) begin
            count <= '0;
            addr  <= '0;
            state <= clr_op ? S_DONE : S_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.opcode;
            key        <= key_in[KW-1:0];
            val        <= {req.value_w2, req.value_w1, req.value_w0};
            res_status <= ST_OK;
            res_found  <= '0;
            s_tot      <= '0;
            s_ctot     <= '0;
            s_u        <= '0;
            s_cu       <= '0;
            addr       <= '0;
            clr_op     <= 1'b0;
            case (req.opcode)
              OP_GET, OP_SET, OP_DEL: state <= S_DIV;
              OP_SUM: state <= S_SUMRD;
              OP_CLEAR: begin
                clr_op <= 1'b1;
                state  <= S_CLR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            addr      <= div_rem[AW-1:0];
            start     <= div_rem[AW-1:0];
            have_tomb <= 1'b0;
            state     <= S_FRD;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rd_tag == TAG_LIVE && rd_key == key) begin
            if (have_tomb) begin
              addr  <= tomb;
              hit   <= tomb;
              tomb  <= addr;
              state <= S_MOVE1;
            end else begin
              hit   <= addr;
              state <= S_HIT;
            end
          end else if (rd_tag == TAG_EMPTY || nb == start) begin
            if (op == OP_SET) begin
              if (count > CW'(upper_cfg)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                addr  <= start;
                tries <= '0;
                state <= S_SRD;
              end
            end else begin
              res_status <= ST_NOTFOUND;
              state      <= S_DONE;
            end
          end else begin
            if (rd_tag == TAG_DELETED && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb      <= addr;
            end
            addr  <= nb;
            state <= S_FRD;
          end
        end
        S_MOVE1: begin
          addr  <= tomb;
          state <= S_MOVE2;
        end
        S_MOVE2: begin
          addr  <= hit;
          state <= S_HIT;
        end
        S_HIT: begin
          if (op == OP_GET) res_found <= rd_val;
          if (op == OP_DEL) begin
            count <= count_dec;
            if (count_dec < CW'(lower_cfg)) res_status <= ST_DEL_LOW;
          end
          state <= S_DONE;
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (rd_tag == TAG_LIVE) begin
            tries <= tries + NW'(1);
            if (tries + NW'(1) == n) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              addr  <= nb;
              state <= S_SRD;
            end
          end else begin
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_SUMRD: state <= S_SUMCHK;
        S_SUMCHK: begin
          if (rd_tag == TAG_LIVE) begin
            s_u   <= s_u + 64'(vb);
            s_cu  <= s_cu + 64'(vc);
            prod  <= va * mul_b;
            state <= S_SUMM2;
          end else if (wrap_end) begin
            state <= S_DONE;
          end else begin
            addr  <= nb;
            state <= S_SUMRD;
          end
        end
        S_SUMM2: begin
          s_tot <= s_tot + prod;
          prod  <= va * mul_b;
          state <= S_SUMM3;
        end
        S_SUMM3: begin
          s_ctot <= s_ctot + prod;
          if (wrap_end) begin
            state <= S_DONE;
          end else begin
            addr  <= nb;
            state <= S_SUMRD;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.found_w0     <= res_found[31:0];
            rsp.found_w1     <= res_found[63:32];
            rsp.found_w2     <= res_found[95:64];
            rsp.entries_now  <= count[CNT_W-1:0];
            rsp.sum_prod_w1  <= s_tot;
            rsp.sum_prod_w2  <= s_ctot;
            rsp.sum_w1       <= s_u;
            rsp.sum_w2       <= s_cu;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = out_valid;
endmodule

### rtl/linear_probe_hash_table.sv
// channel | role                 | beat holds
// req     | sink, valid/ready    | opcode, 256-bit key, three value words
// rsp     | source, valid/ready  | status, found words, entry count, four sums
// cfg     | sink, always ready   | register index and 11-bit data
// get/set/delete: the home bucket comes from the bit-serial remainder unit,
//   then each bucket probed is read through the single memory port
// summarize: sweeps each bucket in use, live ones via one shared multiplier
// clear and the pass after reset: sweep all TABLE_DEPTH entries of the tag memory
// one item at a time; a pending response beat does not block the next request
// top level: instantiates remainder unit, bucket store and sequencer
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lphash_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES = lphash_pkg::DEF_KEY_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  lphash_in_if.sink    req,
  lphash_out_if.source rsp,
  lphash_cfg_if.sink   cfg
);
  import lphash_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;
  localparam int KW = KEY_BYTES * 8;

  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_n;
  logic [NW-1:0] div_rem;
  store_ctl_t    ctl;
  logic [AW-1:0] addr;
  logic [1:0]    tag_wd;
  logic [KW-1:0] key_wd;
  logic [95:0]   val_wd;
  logic [1:0]    rd_tag;
  logic [KW-1:0] rd_key;
  logic [95:0]   rd_val;

  lphash_mod #(.NW(NW)) u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(req.key_w0[31:0]),
    .divisor(div_n), .done(div_done), .rem(div_rem)
  );

  lphash_store #(.TABLE_DEPTH(TABLE_DEPTH), .KW(KW), .AW(AW)) u_store (
    .clk(clk), .ctl(ctl), .addr(addr), .tag_wd(tag_wd), .key_wd(key_wd),
    .val_wd(val_wd), .rd_tag(rd_tag), .rd_key(rd_key), .rd_val(rd_val)
  );

  lphash_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES), .AW(AW), .NW(NW), .KW(KW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
    .div_start(div_start), .div_n(div_n), .div_done(div_done), .div_rem(div_rem),
    .ctl(ctl), .addr(addr), .tag_wd(tag_wd), .key_wd(key_wd), .val_wd(val_wd),
    .rd_tag(rd_tag), .rd_key(rd_key), .rd_val(rd_val)
  );
endmodule

### rtl/lphash_chk.sv
// port-level checker for the hash table, bound to the top level
// depends on lphash_pkg
module lphash_chk (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         rsp_status,
  input logic signed [31:0] rsp_found_w0,
  input logic signed [31:0] rsp_found_w1,
  input logic signed [31:0] rsp_found_w2
);
  import lphash_pkg::*;

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_sweep_after_rst: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("ready during tag sweep after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_NOTFOUND || rsp_status == ST_FULL) |->
    rsp_found_w0 == 0 && rsp_found_w1 == 0 && rsp_found_w2 == 0)
    else $error("found words set on a miss");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("response beat dropped while stalled");
endmodule

bind linear_probe_hash_table lphash_chk u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
  .rsp_found_w0(rsp.found_w0), .rsp_found_w1(rsp.found_w1),
  .rsp_found_w2(rsp.found_w2)
);
